// File: src/climate_reply_reassembler_top_assert.svh
`ifndef CLIMATE_REPLY_REASSEMBLER_TOP_ASSERT_SVH
`define CLIMATE_REPLY_REASSEMBLER_TOP_ASSERT_SVH
// Assertion helpers, clocked on clock, disabled in reset.
`define CRR_NEVER(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("violated: never");
`define CRR_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("violated: implication");
`define CRR_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("violated: next cycle");
`endif

// File: src/crr_pkg.sv
package crr_pkg;
   localparam int CHUNK_BYTES_DEF   = 20;
   localparam int MESSAGE_BYTES_DEF = 256;

   localparam logic [15:0] CMD_STATUS   = 16'h0020;
   localparam logic [15:0] CMD_MODE     = 16'h0030;
   localparam logic [15:0] CMD_SETPOINT = 16'h0040;
   localparam logic [15:0] CMD_FAN      = 16'h0050;
   localparam logic [15:0] CMD_SENSOR   = 16'h0110;
   localparam logic [7:0]  ARG_A        = 8'h20;
   localparam logic [7:0]  ARG_B        = 8'h21;
   localparam logic [7:0]  ARG_T        = 8'h40;

   localparam logic [3:0] OUT_PARTIAL    = 4'd0;
   localparam logic [3:0] OUT_APPLIED    = 4'd1;
   localparam logic [3:0] OUT_OVERSIZE   = 4'd2;
   localparam logic [3:0] OUT_SHORT_CHK  = 4'd3;
   localparam logic [3:0] OUT_BAD_ID     = 4'd4;
   localparam logic [3:0] OUT_TOO_LONG   = 4'd5;
   localparam logic [3:0] OUT_SHORT_MSG  = 4'd6;
   localparam logic [3:0] OUT_BAD_ARG    = 4'd7;
   localparam logic [3:0] OUT_DISCONNECT = 4'd8;

   typedef struct packed {
      logic       func;
      logic [7:0] data_byte;
      logic       chunk_first;
      logic       chunk_last;
   } req_type;

   typedef struct packed {
      logic [3:0]  outcome;
      logic [15:0] command_word;
      logic [2:0]  climate_mode;
      logic [1:0]  fan_speed;
      logic        fan_known;
      logic [15:0] setpoint_high;
      logic        high_known;
      logic [15:0] setpoint_low;
      logic        low_known;
      logic [7:0]  room_temperature;
      logic        room_known;
   } rsp_type;
endpackage

// File: src/climate_reply_reassembler_top.sv
// Climate reply reassembler. Takes one chunk byte per request (or a
// disconnect) and answers each chunk-closing byte and each disconnect with
// one status response carrying the outcome and the published climate values.
// A byte that does not close a chunk is taken in idle and gives no response.
// A closing byte runs a small sequencer over one shared byte fetch from two
// RAMs with one write and one registered read port each (chunk buffer,
// message buffer): checks, a read and a write per payload byte copied into
// the message buffer, and when a message completes a walk of its arguments:
// a start and the fetch of the command word, then per argument its id and
// length plus the value bytes read (at most two, first match only), and a
// finish. A whole message in one id-0 chunk is walked without the copy. The
// request side is not ready from the closing byte until the response is
// taken. A disconnect's response is valid in the cycle after it is taken.
`include "climate_reply_reassembler_top_assert.svh"

module climate_reply_reassembler_top #(
   parameter int CHUNK_BYTES   = crr_pkg::CHUNK_BYTES_DEF,
   parameter int MESSAGE_BYTES = crr_pkg::MESSAGE_BYTES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  crr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output crr_pkg::rsp_type rsp_data
);
   import crr_pkg::*;

   localparam int CNT_W  = $clog2(CHUNK_BYTES + 2);
   localparam int CA_W   = $clog2(CHUNK_BYTES);
   localparam int MA_W   = $clog2(MESSAGE_BYTES);
   localparam int FILL_W = $clog2(MESSAGE_BYTES + CHUNK_BYTES);

   // sequencer states
   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_TAKE    = 4'd1;
   localparam logic [3:0] S_COPY_RD = 4'd2;
   localparam logic [3:0] S_COPY_WR = 4'd3;
   localparam logic [3:0] S_FIN     = 4'd4;
   localparam logic [3:0] S_PSTART  = 4'd5;
   localparam logic [3:0] S_PRD     = 4'd6;
   localparam logic [3:0] S_PDATA   = 4'd7;
   localparam logic [3:0] S_CHK     = 4'd8;
   localparam logic [3:0] S_APPLY   = 4'd9;
   localparam logic [3:0] S_OUT     = 4'd10;

   // which byte the parser is fetching
   localparam logic [2:0] T_WHI  = 3'd0;
   localparam logic [2:0] T_WLO  = 3'd1;
   localparam logic [2:0] T_AID  = 3'd2;
   localparam logic [2:0] T_ALEN = 3'd3;
   localparam logic [2:0] T_V0   = 3'd4;
   localparam logic [2:0] T_V1   = 3'd5;

   logic [3:0]        state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [7:0]        id_ff, id_in, b1_ff, b1_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [7:0]        next_ff, next_in;
   logic [7:0]        mlen_ff, mlen_in;
   logic [CA_W-1:0]   k_ff, k_in;
   logic              src_msg_ff, src_msg_in;
   logic [7:0]        n_ff, n_in;
   logic [7:0]        ptr_ff, ptr_in;
   logic [2:0]        tag_ff, tag_in;
   logic [7:0]        aid_ff, aid_in, alen_ff, alen_in;
   logic [15:0]       word_ff, word_in;
   logic              fa_ff, fa_in, fb_ff, fb_in, ft_ff, ft_in;
   logic [7:0]        la_ff, la_in, lb_ff, lb_in, lt_ff, lt_in;
   logic [7:0]        va0_ff, va0_in, va1_ff, va1_in;
   logic [7:0]        vb0_ff, vb0_in, vb1_ff, vb1_in, vt0_ff, vt0_in;
   logic [2:0]        hit_ff, hit_in;
   logic              on_ff, on_in;
   logic [7:0]        code_ff, code_in;
   logic [2:0]        mode_ff, mode_in;
   logic [2:0]        fan_ff, fan_in;
   logic [16:0]       high_ff, high_in, low_ff, low_in;
   logic [8:0]        room_ff, room_in;
   logic [3:0]        outc_ff, outc_in;
   logic [15:0]       cw_ff, cw_in;

   logic              c_we, m_we;
   logic [CA_W-1:0]   c_waddr, c_raddr;
   logic [MA_W-1:0]   m_waddr, m_raddr;
   logic [7:0]        c_wdata, c_rdata, m_wdata, m_rdata;

   logic              accept;
   logic [CNT_W-1:0]  cnt0, s_len;
   logic [FILL_W-1:0] pos, nf, fill_t;
   logic [7:0]        next_t;
   logic [9:0]        c_ra_full, m_ra_full, arg_end, chk_end;
   logic [7:0]        fetched;
   logic              is_v1;
   logic              new_on;
   logic [7:0]        new_code, fan_v;
   logic              fan_f;
   logic [7:0]        fan_l;
   logic              end_parse;

   crr_ram #(.WIDTH(8), .DEPTH(CHUNK_BYTES)) u_chunk_ram (
      .clock(clock), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
      .raddr(c_raddr), .rdata(c_rdata)
   );

   crr_ram #(.WIDTH(8), .DEPTH(MESSAGE_BYTES)) u_msg_ram (
      .clock(clock), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
      .raddr(m_raddr), .rdata(m_rdata)
   );

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);

   // shared byte fetch address: chunk payload starts one past the id
   assign is_v1     = (tag_ff == T_V1);
   assign m_ra_full = 10'(ptr_ff) + 10'(is_v1);
   assign c_ra_full = (state_ff == S_COPY_RD) ? 10'(k_ff) + 10'd1 : m_ra_full + 10'd1;
   assign c_raddr   = c_ra_full[CA_W-1:0];
   assign m_raddr   = m_ra_full[MA_W-1:0];
   assign fetched   = src_msg_ff ? m_rdata : c_rdata;

   assign s_len   = count_ff - CNT_W'(1);
   assign pos     = fill_ff + FILL_W'(k_ff);
   assign nf      = fill_ff + FILL_W'(n_ff);
   assign arg_end = 10'(ptr_ff) + 10'(fetched);
   assign chk_end = 10'(ptr_ff) + 10'd2;

   // fan query picks its argument by the unit's mode code
   always_comb begin
      fan_f = 1'b0;
      fan_l = 8'd0;
      fan_v = 8'd0;
      case (code_ff)
         8'd0, 8'd2, 8'd3: begin
            fan_f = fa_ff; fan_l = la_ff; fan_v = va0_ff;
         end
         8'd4: begin
            fan_f = fb_ff; fan_l = lb_ff; fan_v = vb0_ff;
         end
         default: begin
            fan_f = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      id_in      = id_ff;
      b1_in      = b1_ff;
      fill_in    = fill_ff;
      next_in    = next_ff;
      mlen_in    = mlen_ff;
      k_in       = k_ff;
      src_msg_in = src_msg_ff;
      n_in       = n_ff;
      ptr_in     = ptr_ff;
      tag_in     = tag_ff;
      aid_in     = aid_ff;
      alen_in    = alen_ff;
      word_in    = word_ff;
      fa_in = fa_ff; fb_in = fb_ff; ft_in = ft_ff;
      la_in = la_ff; lb_in = lb_ff; lt_in = lt_ff;
      va0_in = va0_ff; va1_in = va1_ff; vb0_in = vb0_ff; vb1_in = vb1_ff;
      vt0_in = vt0_ff;
      hit_in  = hit_ff;
      on_in   = on_ff;
      code_in = code_ff;
      mode_in = mode_ff;
      fan_in  = fan_ff;
      high_in = high_ff;
      low_in  = low_ff;
      room_in = room_ff;
      outc_in = outc_ff;
      cw_in   = cw_ff;
      c_we    = 1'b0;
      c_waddr = '0;
      c_wdata = req_data.data_byte;
      m_we    = 1'b0;
      m_waddr = pos[MA_W-1:0];
      m_wdata = c_rdata;
      cnt0    = '0;
      fill_t  = fill_ff;
      next_t  = next_ff;
      new_on  = on_ff;
      new_code = code_ff;
      end_parse = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept && req_data.func) begin
               count_in = '0;
               fill_in  = '0;
               next_in  = '0;
               mode_in  = '0;
               fan_in   = '0;
               high_in  = '0;
               low_in   = '0;
               room_in  = '0;
               outc_in  = OUT_DISCONNECT;
               state_in = S_OUT;
            end else if (accept) begin
               cnt0 = req_data.chunk_first ? '0 : count_ff;
               if (cnt0 < CNT_W'(CHUNK_BYTES)) begin
                  c_we     = 1'b1;
                  c_waddr  = cnt0[CA_W-1:0];
                  count_in = cnt0 + CNT_W'(1);
                  if (cnt0 == '0) id_in = req_data.data_byte;
                  if (cnt0 == CNT_W'(1)) b1_in = req_data.data_byte;
               end else begin
                  count_in = CNT_W'(CHUNK_BYTES + 1);
               end
               if (req_data.chunk_last) state_in = S_TAKE;
            end
         end
         S_TAKE: begin
            count_in = '0;
            n_in     = 8'(s_len);
            k_in     = '0;
            if (count_ff > CNT_W'(CHUNK_BYTES)) begin
               outc_in  = OUT_OVERSIZE;
               state_in = S_OUT;
            end else if (count_ff < CNT_W'(2)) begin
               outc_in  = OUT_SHORT_CHK;
               state_in = S_OUT;
            end else if (id_ff == 8'd0 && 8'(s_len) == b1_ff) begin
               // whole message in one chunk
               src_msg_in = 1'b0;
               state_in   = S_PSTART;
            end else begin
               if (id_ff != next_ff) begin
                  fill_t = '0;
                  next_t = '0;
               end
               if (id_ff == 8'd0) fill_t = '0;
               fill_in = fill_t;
               next_in = next_t;
               if (id_ff != next_ff && id_ff != 8'd0) begin
                  outc_in  = OUT_BAD_ID;
                  state_in = S_OUT;
               end else begin
                  state_in = S_COPY_RD;
               end
            end
         end
         S_COPY_RD: begin
            state_in = S_COPY_WR;
         end
         S_COPY_WR: begin
            if (pos < FILL_W'(MESSAGE_BYTES)) begin
               m_we = 1'b1;
               if (pos == '0) mlen_in = c_rdata;
            end
            if (8'(k_ff) == n_ff - 8'd1) begin
               state_in = S_FIN;
            end else begin
               k_in     = k_ff + CA_W'(1);
               state_in = S_COPY_RD;
            end
         end
         S_FIN: begin
            next_in = next_ff + 8'd1;
            if (nf > FILL_W'(MESSAGE_BYTES) || nf > FILL_W'(mlen_ff)) begin
               fill_in  = '0;
               next_in  = '0;
               outc_in  = OUT_TOO_LONG;
               state_in = S_OUT;
            end else begin
               fill_in = nf;
               if (nf == FILL_W'(mlen_ff)) begin
                  src_msg_in = 1'b1;
                  n_in       = mlen_ff;
                  state_in   = S_PSTART;
               end else begin
                  outc_in  = OUT_PARTIAL;
                  state_in = S_OUT;
               end
            end
         end
         S_PSTART: begin
            fa_in = 1'b0; fb_in = 1'b0; ft_in = 1'b0;
            if (n_ff < 8'd4) begin
               outc_in   = OUT_SHORT_MSG;
               end_parse = 1'b1;
            end else begin
               ptr_in   = 8'd2;
               tag_in   = T_WHI;
               state_in = S_PRD;
            end
         end
         S_PRD: begin
            state_in = S_PDATA;
         end
         S_PDATA: begin
            state_in = S_PRD;
            case (tag_ff)
               T_WHI: begin
                  word_in[15:8] = fetched;
                  ptr_in = 8'd3;
                  tag_in = T_WLO;
               end
               T_WLO: begin
                  word_in[7:0] = fetched;
                  ptr_in   = 8'd4;
                  state_in = S_CHK;
               end
               T_AID: begin
                  aid_in = fetched;
                  ptr_in = ptr_ff + 8'd1;
                  tag_in = T_ALEN;
               end
               T_ALEN: begin
                  alen_in = fetched;
                  ptr_in  = ptr_ff + 8'd1;
                  hit_in  = '0;
                  if (arg_end + 10'd1 > 10'(n_ff)) begin
                     outc_in   = OUT_BAD_ARG;
                     end_parse = 1'b1;
                  end else begin
                     // first argument of each id wins
                     if (aid_ff == ARG_A && !fa_ff) begin
                        fa_in = 1'b1; la_in = fetched; hit_in = 3'b001;
                     end
                     if (aid_ff == ARG_B && !fb_ff) begin
                        fb_in = 1'b1; lb_in = fetched; hit_in = 3'b010;
                     end
                     if (aid_ff == ARG_T && !ft_ff) begin
                        ft_in = 1'b1; lt_in = fetched; hit_in = 3'b100;
                     end
                     if (hit_in != 3'b000 && fetched != 8'd0) begin
                        tag_in = T_V0;
                     end else begin
                        ptr_in   = 8'(arg_end + 10'd1);
                        state_in = S_CHK;
                     end
                  end
               end
               T_V0: begin
                  if (hit_ff[0]) va0_in = fetched;
                  if (hit_ff[1]) vb0_in = fetched;
                  if (hit_ff[2]) vt0_in = fetched;
                  if (alen_ff >= 8'd2) begin
                     tag_in = T_V1;
                  end else begin
                     ptr_in   = ptr_ff + alen_ff;
                     state_in = S_CHK;
                  end
               end
               T_V1: begin
                  if (hit_ff[0]) va1_in = fetched;
                  if (hit_ff[1]) vb1_in = fetched;
                  ptr_in   = ptr_ff + alen_ff;
                  state_in = S_CHK;
               end
               default: begin
                  state_in = S_CHK;
               end
            endcase
         end
         S_CHK: begin
            if (chk_end <= 10'(n_ff)) begin
               tag_in   = T_AID;
               state_in = S_PRD;
            end else begin
               state_in = S_APPLY;
            end
         end
         S_APPLY: begin
            outc_in   = OUT_APPLIED;
            cw_in     = word_ff;
            end_parse = 1'b1;
            if (word_ff == CMD_STATUS || word_ff == CMD_MODE) begin
               if (fa_ff && la_ff == 8'd1) begin
                  if (word_ff == CMD_STATUS) new_on = (va0_ff == 8'd1);
                  else new_code = va0_ff;
                  on_in   = new_on;
                  code_in = new_code;
                  if (!new_on) begin
                     mode_in = 3'd0;
                  end else if (new_code <= 8'd4) begin
                     mode_in = 3'(new_code) + 3'd1;
                  end
               end
            end else if (word_ff == CMD_SETPOINT) begin
               if (fa_ff && la_ff == 8'd2) high_in = {1'b1, va0_ff, va1_ff};
               if (fb_ff && lb_ff == 8'd2) low_in = {1'b1, vb0_ff, vb1_ff};
            end else if (word_ff == CMD_FAN) begin
               if (fan_f && fan_l == 8'd1) begin
                  if (fan_v == 8'd0) fan_in = 3'b100;
                  else if (fan_v == 8'd1) fan_in = 3'b101;
                  else if (fan_v <= 8'd4) fan_in = 3'b110;
                  else if (fan_v == 8'd5) fan_in = 3'b111;
               end
            end else if (word_ff == CMD_SENSOR) begin
               if (ft_ff && lt_ff == 8'd1) room_in = {1'b1, vt0_ff};
            end
         end
         S_OUT: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // a completed message clears the partial message; a one-chunk one keeps it
      if (end_parse) begin
         state_in = S_OUT;
         if (src_msg_ff) begin
            fill_in = '0;
            next_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         fill_ff  <= '0;
         next_ff  <= '0;
         on_ff    <= 1'b0;
         code_ff  <= '0;
         mode_ff  <= '0;
         fan_ff   <= '0;
         high_ff  <= '0;
         low_ff   <= '0;
         room_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         fill_ff  <= fill_in;
         next_ff  <= next_in;
         on_ff    <= on_in;
         code_ff  <= code_in;
         mode_ff  <= mode_in;
         fan_ff   <= fan_in;
         high_ff  <= high_in;
         low_ff   <= low_in;
         room_ff  <= room_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff      <= id_in;
      b1_ff      <= b1_in;
      mlen_ff    <= mlen_in;
      k_ff       <= k_in;
      src_msg_ff <= src_msg_in;
      n_ff       <= n_in;
      ptr_ff     <= ptr_in;
      tag_ff     <= tag_in;
      aid_ff     <= aid_in;
      alen_ff    <= alen_in;
      word_ff    <= word_in;
      fa_ff <= fa_in; fb_ff <= fb_in; ft_ff <= ft_in;
      la_ff <= la_in; lb_ff <= lb_in; lt_ff <= lt_in;
      va0_ff <= va0_in; va1_ff <= va1_in;
      vb0_ff <= vb0_in; vb1_ff <= vb1_in; vt0_ff <= vt0_in;
      hit_ff  <= hit_in;
      outc_ff <= outc_in;
      cw_ff   <= cw_in;
   end

   // response built from held registers; nothing moves while in S_OUT
   always_comb begin
      rsp_data.outcome          = outc_ff;
      rsp_data.command_word     = (outc_ff == OUT_APPLIED) ? cw_ff : 16'd0;
      rsp_data.climate_mode     = mode_ff;
      rsp_data.fan_speed        = fan_ff[1:0];
      rsp_data.fan_known        = fan_ff[2];
      rsp_data.setpoint_high    = high_ff[15:0];
      rsp_data.high_known       = high_ff[16];
      rsp_data.setpoint_low     = low_ff[15:0];
      rsp_data.low_known        = low_ff[16];
      rsp_data.room_temperature = room_ff[7:0];
      rsp_data.room_known       = room_ff[8];
   end

   `CRR_NEVER(a_no_overlap, req_ready && rsp_valid)
   `CRR_NEXT(a_rsp_frees_req, rsp_valid && rsp_ready, req_ready)
   `CRR_IMPLY(a_fill_bound, 1'b1, fill_ff <= FILL_W'(MESSAGE_BYTES))
   `CRR_NEXT(a_disc_answers, accept && req_data.func,
      rsp_valid && rsp_data.outcome == OUT_DISCONNECT && !rsp_data.fan_known)
endmodule

// File: src/crr_ram.sv
module crr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// File: bench/climate_reply_checker.sv
module climate_reply_checker
   import crr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CHUNK_MAX = CHUNK_BYTES_DEF;
   localparam int MSG_MAX   = MESSAGE_BYTES_DEF;

   logic [7:0]  chunk_buf [CHUNK_MAX];
   logic [7:0]  msg_buf [MSG_MAX];
   int          chunk_len;
   int          msg_fill;
   logic [7:0]  chunk_seq;
   logic        unit_on;
   logic [7:0]  mode_code;
   logic [2:0]  mode_now;
   logic [2:0]  fan_now;
   logic [16:0] high_now;
   logic [16:0] low_now;
   logic [8:0]  room_now;
   rsp_type     status_q [$];

   function automatic void refresh_mode();
      if (!unit_on) begin
         mode_now = 3'd0;
      end else if (mode_code <= 8'd4) begin
         mode_now = 3'(mode_code + 1);
      end
   endfunction

   // Walk id-length-value arguments; the first match per id wins.
   function automatic logic [3:0] walk_message(logic [7:0] m [], int n,
                                               output logic [15:0] word);
      bit fa, fb, ft;
      int oa, la, ob, lb, ot, lt, i, alen, o, l;
      bit f;
      word = '0;
      if (n < 4) return OUT_SHORT_MSG;
      word = {m[2], m[3]};
      i = 4;
      while (i + 2 <= n) begin
         alen = m[i+1];
         if (i + 2 + alen > n) begin
            word = '0;
            return OUT_BAD_ARG;
         end
         if (m[i] == ARG_A && !fa) begin fa = 1; oa = i + 2; la = alen; end
         if (m[i] == ARG_B && !fb) begin fb = 1; ob = i + 2; lb = alen; end
         if (m[i] == ARG_T && !ft) begin ft = 1; ot = i + 2; lt = alen; end
         i += 2 + alen;
      end
      case (word)
         CMD_STATUS, CMD_MODE: begin
            if (fa && la == 1) begin
               if (word == CMD_STATUS) unit_on = (m[oa] == 8'd1);
               else mode_code = m[oa];
               refresh_mode();
            end
         end
         CMD_SETPOINT: begin
            if (fa && la == 2) high_now = {1'b1, m[oa], m[oa+1]};
            if (fb && lb == 2) low_now = {1'b1, m[ob], m[ob+1]};
         end
         CMD_FAN: begin
            if (mode_code == 0 || mode_code == 2 || mode_code == 3) begin
               f = fa; o = oa; l = la;
            end else if (mode_code == 4) begin
               f = fb; o = ob; l = lb;
            end
            if (f && l == 1) begin
               if (m[o] == 0) fan_now = 3'b100;
               else if (m[o] == 1) fan_now = 3'b101;
               else if (m[o] <= 4) fan_now = 3'b110;
               else if (m[o] == 5) fan_now = 3'b111;
            end
         end
         CMD_SENSOR: if (ft && lt == 1) room_now = {1'b1, m[ot]};
         default: ;
      endcase
      return OUT_APPLIED;
   endfunction

   function automatic logic [3:0] close_chunk(int len, output logic [15:0] word);
      logic [7:0] one [];
      logic [7:0] id;
      int s, nf;
      word = '0;
      if (len > CHUNK_MAX) return OUT_OVERSIZE;
      if (len < 2) return OUT_SHORT_CHK;
      id = chunk_buf[0];
      s = len - 1;
      if (id == 0 && s == chunk_buf[1]) begin
         one = new[s];
         for (int k = 0; k < s; k++) one[k] = chunk_buf[k+1];
         return walk_message(one, s, word);
      end
      if (id != chunk_seq) begin
         msg_fill = 0;
         chunk_seq = 0;
         if (id != 0) return OUT_BAD_ID;
      end
      if (id == 0) msg_fill = 0;
      nf = msg_fill + s;
      for (int k = 0; k < s; k++)
         if (msg_fill + k < MSG_MAX) msg_buf[msg_fill+k] = chunk_buf[k+1];
      chunk_seq++;
      if (nf > MSG_MAX || nf > msg_buf[0]) begin
         msg_fill = 0;
         chunk_seq = 0;
         return OUT_TOO_LONG;
      end
      msg_fill = nf;
      if (msg_fill == msg_buf[0]) begin
         one = new[msg_fill];
         for (int k = 0; k < msg_fill; k++) one[k] = msg_buf[k];
         msg_fill = 0;
         chunk_seq = 0;
         return walk_message(one, nf, word);
      end
      return OUT_PARTIAL;
   endfunction

   function automatic void predict_request(req_type r);
      rsp_type e;
      logic [15:0] word;
      word = '0;
      if (r.func) begin
         chunk_len = 0; msg_fill = 0; chunk_seq = 0;
         mode_now = 0; fan_now = 0; high_now = 0; low_now = 0; room_now = 0;
         e.outcome = OUT_DISCONNECT;
      end else begin
         if (r.chunk_first) chunk_len = 0;
         if (chunk_len < CHUNK_MAX) begin
            chunk_buf[chunk_len] = r.data_byte;
            chunk_len++;
         end else begin
            chunk_len = CHUNK_MAX + 1;
         end
         if (!r.chunk_last) return;
         e.outcome = close_chunk(chunk_len, word);
         chunk_len = 0;
      end
      e.command_word     = (e.outcome == OUT_APPLIED) ? word : 16'd0;
      e.climate_mode     = mode_now;
      e.fan_speed        = fan_now[1:0];
      e.fan_known        = fan_now[2];
      e.setpoint_high    = high_now[15:0];
      e.high_known       = high_now[16];
      e.setpoint_low     = low_now[15:0];
      e.low_known        = low_now[16];
      e.room_temperature = room_now[7:0];
      e.room_known       = room_now[8];
      status_q.push_back(e);
   endfunction

   function automatic bit check_field(string name, logic [15:0] exp_v,
                                      logic [15:0] got_v);
      if (got_v !== exp_v) begin
         $error("%s: expected %0h, got %0h", name, exp_v, got_v);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic compare_status(rsp_type got);
      rsp_type exp;
      bit bad;
      if (status_q.size() == 0) begin
         $error("unexpected response %h", got);
         fail_count++;
         return;
      end
      exp = status_q.pop_front();
      bad |= check_field("outcome", 16'(exp.outcome), 16'(got.outcome));
      bad |= check_field("command_word", exp.command_word, got.command_word);
      bad |= check_field("climate_mode", 16'(exp.climate_mode), 16'(got.climate_mode));
      bad |= check_field("fan_speed", 16'(exp.fan_speed), 16'(got.fan_speed));
      bad |= check_field("fan_known", 16'(exp.fan_known), 16'(got.fan_known));
      bad |= check_field("setpoint_high", exp.setpoint_high, got.setpoint_high);
      bad |= check_field("high_known", 16'(exp.high_known), 16'(got.high_known));
      bad |= check_field("setpoint_low", exp.setpoint_low, got.setpoint_low);
      bad |= check_field("low_known", 16'(exp.low_known), 16'(got.low_known));
      bad |= check_field("room_temperature", 16'(exp.room_temperature),
                         16'(got.room_temperature));
      bad |= check_field("room_known", 16'(exp.room_known), 16'(got.room_known));
      if (bad) fail_count++;
   endtask

   initial begin
      fail_count = 0;
      pending_count = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         chunk_len = 0; msg_fill = 0; chunk_seq = 0;
         unit_on = 0; mode_code = 0; mode_now = 0;
         fan_now = 0; high_now = 0; low_now = 0; room_now = 0;
         status_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) compare_status(rsp_data);
         if (req_valid && req_ready) predict_request(req_data);
      end
      pending_count = status_q.size();
   end
endmodule

// File: bench/tb.sv
module tb;
   import crr_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 0;
   rsp_type rsp_data;
   int      fail_count;
   int      pending_count;
   bit      hold_off = 0;   // long receiver stall, owned by its own process

   always #6 clock = ~clock;

   climate_reply_reassembler_top uut (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data
   );

   climate_reply_checker chk (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data, .fail_count, .pending_count
   );

   // A chunk stream is a queue of requests built up, then sent in one go.
   req_type  plan [$];
   int       burst_left;

   // Offer one request at the falling edge and hold it until accepted.
   // Sender goes in bursts; a random gap, possibly none, is inserted when a burst runs out.
   task automatic send_request(req_type r);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 30);
      end
      burst_left--;
      req_valid <= 1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic flush_plan();
      while (plan.size() > 0) send_request(plan.pop_front());
   endtask

   task automatic push_byte(logic [7:0] b, bit first, bit last);
      req_type r;
      r.func = 0;
      r.data_byte = b;
      r.chunk_first = first;
      r.chunk_last = last;
      plan.push_back(r);
   endtask

   task automatic push_disconnect();
      req_type r;
      r = '0;
      r.func = 1;
      r.data_byte = 8'($urandom);
      r.chunk_first = $urandom_range(0, 1);
      r.chunk_last = $urandom_range(0, 1);
      plan.push_back(r);
   endtask

   task automatic push_chunk(logic [7:0] bytes [$]);
      for (int k = 0; k < bytes.size(); k++)
         push_byte(bytes[k], k == 0, k == bytes.size() - 1);
   endtask

   // Split a message into chunks with ids 0,1,2...; a single-chunk message
   // is sent as id 0, which the block parses at once.
   task automatic push_message(logic [7:0] msg [$], int max_pay);
      logic [7:0] c [$];
      int pos, id, n;
      pos = 0;
      id = 0;
      while (pos < msg.size()) begin
         n = $urandom_range(1, max_pay);
         c = {8'(id)};
         for (int k = 0; k < n && pos < msg.size(); k++) begin
            c.push_back(msg[pos]);
            pos++;
         end
         push_chunk(c);
         id++;
      end
   endtask

   // Mostly well-formed message: length, pad byte, command, args.
   function automatic void build_message(logic [15:0] word,
                                         ref logic [7:0] msg [$]);
      int nargs;
      logic [7:0] aid, alen;
      msg = {8'd0, 8'($urandom), word[15:8], word[7:0]};
      nargs = $urandom_range(0, 4);
      for (int a = 0; a < nargs; a++) begin
         case ($urandom_range(0, 3))
            0: aid = ARG_A;
            1: aid = ARG_B;
            2: aid = ARG_T;
            default: aid = 8'($urandom);
         endcase
         alen = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 5))
                                            : 8'($urandom_range(1, 2));
         msg.push_back(aid);
         msg.push_back(alen);
         for (int k = 0; k < alen; k++)
            msg.push_back(($urandom_range(0, 1)) ? 8'($urandom_range(0, 6))
                                                  : 8'($urandom));
      end
      if ($urandom_range(0, 9) == 0) msg.push_back(8'($urandom));
      // occasionally break the walk by overrunning the last argument
      if ($urandom_range(0, 12) == 0 && nargs > 0) void'(msg.pop_back());
      if (msg.size() > 255) msg = msg[0:254];
      msg[0] = 8'(msg.size());
   endfunction

   function automatic logic [15:0] pick_word();
      case ($urandom_range(0, 6))
         0: return CMD_STATUS;
         1: return CMD_MODE;
         2: return CMD_SETPOINT;
         3: return CMD_FAN;
         4: return CMD_SENSOR;
         5: return 16'($urandom);
         default: return CMD_STATUS;
      endcase
   endfunction

   task automatic wait_drained();
      req_valid <= 0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
   endtask

   // Receiver: stalls on its own pattern; quiet stretches without stalls.
   initial begin
      int phase;
      @(negedge clock);
      while (reset) @(negedge clock);
      phase = 0;
      forever begin
         @(negedge clock);
         phase++;
         if (hold_off) rsp_ready <= 0;
         else if ((phase / 64) % 3 == 2) rsp_ready <= 1;
         else rsp_ready <= ($urandom_range(0, 99) < 60);
      end
   end

   initial begin
      #20ms;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      logic [7:0] msg [$];
      logic [7:0] c [$];
      int sent;
      burst_left = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // Directed: short chunk, bad id, oversize, short message, status on,
      // two modes, fan at the extremes, setpoints, room, bad argument, disconnect.
      push_chunk({8'h00});
      push_chunk({8'h07, 8'hff});
      c = {8'h00};
      for (int k = 0; k < 24; k++) c.push_back(8'($urandom));
      push_chunk(c);
      push_chunk({8'h00, 8'h02, 8'h00});
      push_chunk({8'h00, 8'h07, 8'h00, 8'h00, 8'h20, ARG_A, 8'h01, 8'h01});
      push_chunk({8'h00, 8'h07, 8'h00, 8'h00, 8'h30, ARG_A, 8'h01, 8'h04});
      push_chunk({8'h00, 8'h07, 8'h00, 8'h00, 8'h30, ARG_A, 8'h01, 8'h00});
      push_chunk({8'h00, 8'h07, 8'h00, 8'h00, 8'h50, ARG_A, 8'h01, 8'h05});
      push_chunk({8'h00, 8'h07, 8'h00, 8'h00, 8'h50, ARG_A, 8'h01, 8'h09});
      push_chunk({8'h00, 8'h0c, 8'h00, 8'h00, 8'h40, ARG_A, 8'h02, 8'hff, 8'hff,
                  ARG_B, 8'h02, 8'h00, 8'h00});
      push_chunk({8'h00, 8'h07, 8'h00, 8'h01, 8'h10, ARG_T, 8'h01, 8'hff});
      push_chunk({8'h00, 8'h07, 8'h00, 8'h01, 8'h10, ARG_T, 8'h05, 8'h00});
      push_chunk({8'h00, 8'h03, 8'h00, 8'h00});
      push_chunk({8'h01, 8'h11});
      push_disconnect();
      flush_plan();
      wait_drained();

      // Long receiver hold-off while the sender keeps offering requests.
      hold_off = 1;
      fork
         begin
            repeat (300) @(negedge clock);
            hold_off = 0;
         end
         begin
            for (int k = 0; k < 6; k++) begin
               build_message(pick_word(), msg);
               push_message(msg, 19);
            end
            flush_plan();
         end
      join
      wait_drained();

      sent = 0;
      while (sent < 540) begin
         case ($urandom_range(0, 19))
            0: push_disconnect();
            1: begin
               // noise chunk, any length, random first/last bits
               for (int k = $urandom_range(1, 25); k > 0; k--)
                  push_byte(8'($urandom), $urandom_range(0, 3) == 0,
                            $urandom_range(0, 5) == 0);
               push_byte(8'($urandom), 0, 1);
            end
            2: begin
               // long multi-chunk message near the length limit
               build_message(pick_word(), msg);
               while (msg.size() < 200 + $urandom_range(0, 55))
                  msg.push_back(8'($urandom));
               msg[0] = 8'(msg.size() - $urandom_range(0, 1));
               push_message(msg, 19);
            end
            3: begin
               // sequence that may break: a second chunk with a random id from 0 to 3
               build_message(pick_word(), msg);
               push_chunk({8'h00, msg[0], msg[1]});
               push_chunk({8'($urandom_range(0, 3)), 8'($urandom)});
            end
            default: begin
               build_message(pick_word(), msg);
               push_message(msg, $urandom_range(0, 1) ? 19 : 4);
            end
         endcase
         sent += plan.size();
         flush_plan();
         if ($urandom_range(0, 60) == 0) wait_drained();
      end
      wait_drained();
      repeat (600) @(negedge clock);

      if (fail_count == 0 && pending_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule

// File: sim.f
+incdir+src
src/crr_pkg.sv
src/crr_ram.sv
src/climate_reply_reassembler_top.sv
bench/climate_reply_checker.sv
bench/tb.sv
